// ----- rtl/cle_pkg.sv -----
// Shared types and constants for the cursor line editor.
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;

	localparam int LINE_DEPTH_DEF = 64;
	localparam int QUEUE_DEPTH    = 2;
	localparam int KEY_W          = 8;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_KEY      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_KEY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE_KEY = 2'd2;

	localparam logic [KEY_W-1:0] LEFT_KEY_RST      = 8'd60;
	localparam logic [KEY_W-1:0] RIGHT_KEY_RST     = 8'd62;
	localparam logic [KEY_W-1:0] BACKSPACE_KEY_RST = 8'd45;

	typedef enum logic [1:0] {
		OP_LEFT,
		OP_RIGHT,
		OP_BKSP,
		OP_INSERT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic             eol;
	} cmd_t;

	typedef enum logic {
		ST_EDIT,
		ST_FLUSH
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/cle_front.sv -----
// Front end: key registers and keystroke classification.
`timescale 1ns / 1ps
`default_nettype none
module cle_front import cle_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [KEY_W-1:0]     s_tdata,   // [7:0] key_code
	input  wire logic                 s_tlast,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [KEY_W-1:0]     cfg_wdata,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output cmd_t                      push_cmd
);

	logic [KEY_W-1:0] left_key_q;
	logic [KEY_W-1:0] right_key_q;
	logic [KEY_W-1:0] bksp_key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_key_q  <= LEFT_KEY_RST;
			right_key_q <= RIGHT_KEY_RST;
			bksp_key_q  <= BACKSPACE_KEY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEFT_KEY:      left_key_q  <= cfg_wdata;
				CFG_RIGHT_KEY:     right_key_q <= cfg_wdata;
				CFG_BACKSPACE_KEY: bksp_key_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// left wins over right, right over backspace
	always_comb begin
		push_cmd.key = s_tdata;
		push_cmd.eol = s_tlast;
		if (s_tdata == left_key_q)       push_cmd.op = OP_LEFT;
		else if (s_tdata == right_key_q) push_cmd.op = OP_RIGHT;
		else if (s_tdata == bksp_key_q)  push_cmd.op = OP_BKSP;
		else                             push_cmd.op = OP_INSERT;
	end

	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;

endmodule
`default_nettype wire

// ----- rtl/cle_queue.sv -----
// Small command queue between front end and edit engine.
`timescale 1ns / 1ps
`default_nettype none
module cle_queue import cle_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      out_cmd
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cle_back.sv -----
// Edit engine: line cells, cursor, flush sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
module cle_back import cle_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire cmd_t             cmd,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [KEY_W-1:0]      m_tdata,   // [7:0] char_out
	output logic                  m_tlast,
	output logic [1:0]            m_tuser    // [0] empty_line, [1] overflowed
);

	localparam int LEN_W = $clog2(LINE_DEPTH + 1);

	logic [KEY_W-1:0] cells_q [LINE_DEPTH];
	logic [KEY_W-1:0] cells_d [LINE_DEPTH];
	logic [LEN_W-1:0] length_q, length_d;
	logic [LEN_W-1:0] cursor_q, cursor_d;
	logic             ovf_q, ovf_d;
	state_t           state_q, state_d;

	logic             out_valid_q, out_valid_d;
	logic [KEY_W-1:0] char_q, char_d;
	logic             last_q, last_d;
	logic             empty_q, empty_d;
	logic             oflag_q, oflag_d;
	logic             load_ok;

	assign load_ok = !out_valid_q || m_tready;

	always_comb begin
		cells_d     = cells_q;
		length_d    = length_q;
		cursor_d    = cursor_q;
		ovf_d       = ovf_q;
		state_d     = state_q;
		out_valid_d = out_valid_q && !m_tready;
		char_d      = char_q;
		last_d      = last_q;
		empty_d     = empty_q;
		oflag_d     = oflag_q;
		cmd_ready   = 1'b0;

		case (state_q)
			ST_EDIT: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					case (cmd.op)
						OP_LEFT: begin
							if (cursor_q != '0) cursor_d = cursor_q - 1'b1;
						end
						OP_RIGHT: begin
							if (cursor_q < length_q) cursor_d = cursor_q + 1'b1;
						end
						OP_BKSP: begin
							if (cursor_q != '0) begin
								// close the gap: every cell from cursor-1 up pulls its neighbor
								for (int i = 0; i < LINE_DEPTH - 1; i++) begin
									if (LEN_W'(i) + 1'b1 >= cursor_q) cells_d[i] = cells_q[i + 1];
								end
								length_d = length_q - 1'b1;
								cursor_d = cursor_q - 1'b1;
							end
						end
						OP_INSERT: begin
							if (length_q == LEN_W'(LINE_DEPTH)) begin
								ovf_d = 1'b1;
							end else begin
								if (cursor_q == '0) cells_d[0] = cmd.key;
								for (int i = 1; i < LINE_DEPTH; i++) begin
									if (LEN_W'(i) == cursor_q)     cells_d[i] = cmd.key;
									else if (LEN_W'(i) > cursor_q) cells_d[i] = cells_q[i - 1];
								end
								length_d = length_q + 1'b1;
								cursor_d = cursor_q + 1'b1;
							end
						end
						default: ;
					endcase
					if (cmd.eol) begin
						state_d  = ST_FLUSH;
						cursor_d = '0;
					end
				end
			end
			ST_FLUSH: begin
				if (load_ok) begin
					out_valid_d = 1'b1;
					oflag_d     = ovf_q;
					if (length_q == '0) begin
						char_d  = '0;
						last_d  = 1'b1;
						empty_d = 1'b1;
						ovf_d   = 1'b0;
						state_d = ST_EDIT;
					end else begin
						// shift the line out from cell 0
						char_d  = cells_q[0];
						last_d  = (length_q == LEN_W'(1));
						empty_d = 1'b0;
						for (int i = 0; i < LINE_DEPTH - 1; i++) cells_d[i] = cells_q[i + 1];
						length_d = length_q - 1'b1;
						if (length_q == LEN_W'(1)) begin
							ovf_d   = 1'b0;
							state_d = ST_EDIT;
						end
					end
				end
			end
			default: state_d = ST_EDIT;
		endcase
	end

	always_ff @(posedge clk) begin
		cells_q <= cells_d;
		char_q  <= char_d;
		last_q  <= last_d;
		empty_q <= empty_d;
		oflag_q <= oflag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			cursor_q    <= '0;
			ovf_q       <= 1'b0;
			state_q     <= ST_EDIT;
			out_valid_q <= 1'b0;
		end else begin
			length_q    <= length_d;
			cursor_q    <= cursor_d;
			ovf_q       <= ovf_d;
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;
	assign m_tuser  = {oflag_q, empty_q};

endmodule
`default_nettype wire

// ----- rtl/cursor_line_editor_unit.sv -----
// Top level of the cursor line editor.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s       | in  | s_tvalid/s_tready  | tdata[7:0] key_code, tlast end_of_line
//  m       | out | m_tvalid/m_tready  | tdata[7:0] char_out, tlast last,
//          |     |                    | tuser[0] empty_line, tuser[1] overflowed
//  cfg     | in  | cfg_we             | cfg_index, cfg_wdata (0 left, 1 right, 2 bksp)
//
// The edit engine applies each key as it is taken; insert and backspace shift
// the cells above the cursor. An end-of-line key starts the flush sequencer,
// which shifts the line out through the output register (a marker if empty).
// A two-entry command queue lets the input keep taking keys during a flush
// until it fills; a stalled output holds the flush.
// Reset clears length, cursor, overflow flag, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none
module cursor_line_editor_unit import cle_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [KEY_W-1:0]     s_tdata,   // [7:0] key_code
	input  wire logic                 s_tlast,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [KEY_W-1:0]          m_tdata,   // [7:0] char_out
	output logic                      m_tlast,
	output logic [1:0]                m_tuser,   // [0] empty_line, [1] overflowed
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [KEY_W-1:0]     cfg_wdata
);

	logic push_valid, push_ready;
	cmd_t push_cmd;
	logic pop_valid, pop_ready;
	cmd_t pop_cmd;

	cle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	cle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_cmd    (push_cmd),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_cmd   (pop_cmd)
	);

	cle_back #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire
